// ===== hdl/lpd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants of the length-prefixed packet deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

  localparam int unsigned HDR_BYTES    = 9;
  localparam int unsigned MAX_PKT_W    = 17;
  localparam logic [MAX_PKT_W-1:0] MAX_PKT_RESET = 17'd4096;
  localparam logic [7:0]  BYTE_MASK    = 8'hFF;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_BODY   = 1'b1;

  localparam int unsigned CFG_ADDR_W   = 3;
  localparam logic [0:0]  REG_MAX_PKT  = 1'b0;

  typedef struct packed {
    logic        kind;
    logic [7:0]  body_byte;
    logic        last;
    logic [31:0] body_length;
    logic [31:0] header_value;
    logic [7:0]  packet_type;
    logic        oversize;
  } lpd_entry_t;

endpackage

// ===== hdl/lpd_front.sv =====
// ----------------------------------------------------------------------------
// lpd_front
// Header assembly and per-beat classification; emits one queue entry per
// header and per delivered body byte, drops skipped body bytes.
// ----------------------------------------------------------------------------
module lpd_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  logic [7:0]                      data_byte,
  input  logic [lpd_pkg::MAX_PKT_W-1:0]   max_pkt,
  output logic                            wr_valid,
  output lpd_pkg::lpd_entry_t             wr_entry
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_SKIP   = 2'd2
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [31:0] length_r, length_nxt;
  logic [31:0] value_r, value_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [31:0] remain_r, remain_nxt;

  logic [32:0] total;
  logic        over;
  logic        len_zero;
  logic        rem_le1;
  logic [31:0] remain_dec;

  assign total      = {1'b0, length_r} + 33'(lpd_pkg::HDR_BYTES);
  assign over       = total > {16'd0, max_pkt};
  assign len_zero   = (length_r == 32'd0);
  assign rem_le1    = (remain_r <= 32'd1);
  assign remain_dec = (remain_r != 32'd0) ? remain_r - 32'd1 : remain_r;

  always_comb begin
    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    length_nxt  = length_r;
    value_nxt   = value_r;
    type_nxt    = type_r;
    remain_nxt  = remain_r;
    wr_valid    = 1'b0;
    wr_entry.kind         = lpd_pkg::KIND_HEADER;
    wr_entry.body_byte    = 8'd0;
    wr_entry.last         = 1'b0;
    wr_entry.body_length  = length_r;
    wr_entry.header_value = value_r;
    wr_entry.packet_type  = type_r;
    wr_entry.oversize     = 1'b0;
    if (accept) begin
      unique case (phase_r)
        PH_SKIP: begin
          remain_nxt = remain_dec;
          if (rem_le1) begin
            phase_nxt = PH_HEADER;
          end
        end
        PH_BODY: begin
          wr_valid           = 1'b1;
          wr_entry.kind      = lpd_pkg::KIND_BODY;
          wr_entry.body_byte = data_byte & lpd_pkg::BYTE_MASK;
          wr_entry.last      = rem_le1;
          remain_nxt         = remain_dec;
          if (rem_le1) begin
            phase_nxt = PH_HEADER;
          end
        end
        default: begin
          // header assembly, little-endian words shift in from the top
          phase_nxt   = PH_HEADER;
          hdr_cnt_nxt = hdr_cnt_r + 4'd1;
          if (hdr_cnt_r < 4'd4) begin
            length_nxt = {data_byte, length_r[31:8]};
          end else if (hdr_cnt_r < 4'd8) begin
            value_nxt = {data_byte, value_r[31:8]};
          end else begin
            type_nxt = data_byte;
          end
          if (hdr_cnt_r == 4'(lpd_pkg::HDR_BYTES - 1)) begin
            wr_valid             = 1'b1;
            wr_entry.kind        = lpd_pkg::KIND_HEADER;
            wr_entry.last        = len_zero;
            wr_entry.packet_type = data_byte;
            wr_entry.oversize    = over;
            hdr_cnt_nxt          = 4'd0;
            if (over && !len_zero) begin
              remain_nxt = length_r;
              phase_nxt  = PH_SKIP;
            end else if (!over && (data_byte != 8'd0) && !len_zero) begin
              remain_nxt = length_r;
              phase_nxt  = PH_BODY;
            end else begin
              remain_nxt = 32'd0;
              phase_nxt  = PH_HEADER;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hdr_cnt_r <= 4'd0;
      length_r  <= 32'd0;
      value_r   <= 32'd0;
      type_r    <= 8'd0;
      remain_r  <= 32'd0;
    end else begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      length_r  <= length_nxt;
      value_r   <= value_nxt;
      type_r    <= type_nxt;
      remain_r  <= remain_nxt;
    end
  end

  a_body_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY || phase_r == PH_SKIP) |-> (remain_r != 32'd0))
    else $error("body/skip phase with zero remaining count");

  a_hdr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_cnt_r < 4'(lpd_pkg::HDR_BYTES))
    else $error("header byte count out of range");

  a_skip_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SKIP) |-> !wr_valid)
    else $error("entry emitted while skipping");

endmodule

// ===== hdl/lpd_fifo.sv =====
// ----------------------------------------------------------------------------
// lpd_fifo
// Short flop-based queue between front and back.
// ----------------------------------------------------------------------------
module lpd_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  lpd_pkg::lpd_entry_t  wr_data,
  input  logic                 rd_en,
  output lpd_pkg::lpd_entry_t  rd_data,
  output logic                 is_full,
  output logic                 is_empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lpd_pkg::lpd_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign is_empty = (count_r == '0);
  assign rd_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!wr_en && rd_en) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    is_full |-> !wr_en || rd_en)
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !is_empty)
    else $error("queue underflow");

endmodule

// ===== hdl/lpd_back.sv =====
// ----------------------------------------------------------------------------
// lpd_back
// Result stage: drains the queue into the output register.
// ----------------------------------------------------------------------------
module lpd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  lpd_pkg::lpd_entry_t  q_data,
  output logic                 q_pop,
  input  logic                 pop,
  output logic                 empty,
  output lpd_pkg::lpd_entry_t  res
);

  logic                out_valid_r, out_valid_nxt;
  lpd_pkg::lpd_entry_t res_r;

  assign q_pop         = !q_empty && (!out_valid_r || pop);
  assign out_valid_nxt = q_pop || (out_valid_r && !pop);
  assign empty         = !out_valid_r;
  assign res           = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= q_data;
    end
  end

endmodule

// ===== hdl/length_prefixed_packet_deframer_unit.sv =====
// Path: a result beat is written into the entry queue at the edge that
// accepts its input beat, then loaded into the output register once it is
// at the queue head and the result side has room.
// Throughput: one input beat per cycle while full is low; full rises only
// when the internal queue is full because the result side is stalled.
// Reset: synchronous active-low; parser returns to header assembly,
// queue and output register empty, max_packet_bytes = 4096.
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer_unit
// Top level: APB register, front parser, entry queue, result stage.
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  logic [7:0]                         in_data_byte,
  output logic                               empty,
  input  logic                               pop,
  output logic                               out_kind,
  output logic [7:0]                         out_body_byte,
  output logic                               out_last,
  output logic [31:0]                        out_body_length,
  output logic [31:0]                        out_header_value,
  output logic [7:0]                         out_packet_type,
  output logic                               out_oversize,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lpd_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  logic [lpd_pkg::MAX_PKT_W-1:0] max_pkt_r;
  logic                          reg_hit;
  logic                          accept;
  logic                          fr_valid;
  lpd_pkg::lpd_entry_t           fr_entry;
  lpd_pkg::lpd_entry_t           q_data;
  logic                          q_full;
  logic                          q_empty;
  logic                          q_pop;
  lpd_pkg::lpd_entry_t           res;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == lpd_pkg::REG_MAX_PKT);
  assign prdata  = reg_hit ? {15'd0, max_pkt_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_pkt_r <= lpd_pkg::MAX_PKT_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      max_pkt_r <= pwdata[lpd_pkg::MAX_PKT_W-1:0];
    end
  end

  assign full   = q_full;
  assign accept = push && !q_full;

  lpd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_data_byte),
    .max_pkt   (max_pkt_r),
    .wr_valid  (fr_valid),
    .wr_entry  (fr_entry)
  );

  lpd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (fr_valid),
    .wr_data  (fr_entry),
    .rd_en    (q_pop),
    .rd_data  (q_data),
    .is_full  (q_full),
    .is_empty (q_empty)
  );

  lpd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .res     (res)
  );

  assign out_kind         = res.kind;
  assign out_body_byte    = res.body_byte;
  assign out_last         = res.last;
  assign out_body_length  = res.body_length;
  assign out_header_value = res.header_value;
  assign out_packet_type  = res.packet_type;
  assign out_oversize     = res.oversize;

endmodule
